@@ rtl/core/keith_pkg.sv @@
// Shared types and constants for the Keith number tester.
`timescale 1ns / 1ps

package keith_pkg;

  // Width of one window term; terms never exceed the candidate
  localparam int TERM_W = 32;
  // Width of the running window sum (at most nine terms below 10^9 each)
  localparam int SUM_W  = 36;

  typedef logic [TERM_W-1:0] term_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Commands broadcast from the sequencer to every cell of the window
  typedef struct packed {
    logic clr;   // drop all tail marks at the start of a beat
    logic load;  // shift digits upward from cell 0
    logic run;   // shift terms downward, tail cell takes the new term
  } cell_cmd_t;

endpackage

@@ rtl/core/keith_number_test.sv @@
// Top level of the Keith number tester: digit split, window of cells, step sequencer.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   input    | in_valid, in_stall, candidate[31:0]      | in
//   output   | out_valid, out_stall, is_keith           | out
//
// An item is accepted, then its d decimal digits are split off (one divide-by-ten per
// cycle), then k window steps of one add each run, and then the result is posted.
// Out-of-range candidates go from acceptance straight to posting the result.
// The result register frees the input side: a new beat is taken while a result waits.
// Synchronous active-high reset clears the sequencer and the result valid.
`timescale 1ns / 1ps

module keith_number_test import keith_pkg::*; #(
  parameter int MAX_DIGITS = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] candidate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_keith
);

  localparam logic [31:0] RECIP10   = 32'hCCCCCCCD;
  localparam logic [7:0]  STEP_LAST = 8'd255;

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] v;
    v = 64'd1;
    for (int i = 0; i < n; i++) begin
      v = v * 64'd10;
    end
    return v;
  endfunction

  localparam logic [63:0] LIMIT = pow10(MAX_DIGITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_RUN  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t      state, state_next;
  logic [31:0] cand;
  logic [31:0] rest;
  sum_t        sum;
  logic        first;
  logic [7:0]  step_cnt;
  logic        res;

  logic        in_take;
  logic        out_free;
  logic        in_range;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] rem_full;
  logic [3:0]  digit;
  logic        hit;
  logic        over;
  logic [SUM_W:0] sum_grow;
  cell_cmd_t   cmd;

  term_t cell_term [MAX_DIGITS];
  logic  cell_tail [MAX_DIGITS];

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_range = (64'(candidate) >= 64'd10) && (64'(candidate) < LIMIT);

  // Divide the remaining value by ten through a reciprocal multiply
  assign prod     = 64'(rest) * 64'(RECIP10);
  assign quot     = {3'b000, prod[63:35]};
  assign rem_full = rest - (quot << 3) - (quot << 1);
  assign digit    = rem_full[3:0];

  // Compare the current window sum with the candidate
  assign hit      = (sum == SUM_W'(cand));
  assign over     = (sum >  SUM_W'(cand));
  // Next sum: the new term enters and the oldest term leaves
  assign sum_grow = {sum, 1'b0} - (SUM_W+1)'(cell_term[0]);

  assign cmd.clr  = in_take;
  assign cmd.load = (state == S_LOAD);
  assign cmd.run  = (state == S_RUN) && !hit && !over;

  // Window of cells: digits shift up from cell 0, terms shift down toward cell 0
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    term_t below_term;
    logic  below_tail;
    term_t above_term;
    if (i == 0) begin : g_bottom
      assign below_term = TERM_W'(digit);
      assign below_tail = first;
    end else begin : g_inner
      assign below_term = cell_term[i-1];
      assign below_tail = cell_tail[i-1];
    end
    if (i == MAX_DIGITS - 1) begin : g_top
      assign above_term = '0;
    end else begin : g_below_top
      assign above_term = cell_term[i+1];
    end
    keith_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .below_term (below_term),
      .below_tail (below_tail),
      .above_term (above_term),
      .new_term   (sum[TERM_W-1:0]),
      .term       (cell_term[i]),
      .tail       (cell_tail[i])
    );
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = in_range ? S_LOAD : S_FIN;
        end
      end
      S_LOAD: begin
        if (quot == 32'd0) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (hit || over || step_cnt == STEP_LAST) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers: latch the beat, split digits, advance the window sum
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          cand     <= candidate;
          rest     <= candidate;
          sum      <= '0;
          first    <= 1'b1;
          step_cnt <= '0;
          res      <= 1'b0;
        end
      end
      S_LOAD: begin
        rest  <= quot;
        sum   <= sum + SUM_W'(digit);
        first <= 1'b0;
      end
      S_RUN: begin
        if (hit) begin
          res <= 1'b1;
        end else if (!over) begin
          sum      <= sum_grow[SUM_W-1:0];
          step_cnt <= step_cnt + 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: post when the sequencer finishes, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      is_keith <= res;
    end
  end

endmodule

@@ rtl/core/keith_cell.sv @@
// One window cell: holds a single term and a tail mark for the window end.
`timescale 1ns / 1ps

module keith_cell import keith_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  term_t     below_term,
  input  logic      below_tail,
  input  term_t     above_term,
  input  term_t     new_term,
  output term_t     term,
  output logic      tail
);

  // Tail mark: clear on a new beat, shift upward with the digits
  always_ff @(posedge clk) begin
    if (rst) begin
      tail <= 1'b0;
    end else if (cmd.clr) begin
      tail <= 1'b0;
    end else if (cmd.load) begin
      tail <= below_tail;
    end
  end

  // Term: take the digit from below while loading, advance downward while running
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      term <= below_term;
    end else if (cmd.run) begin
      term <= tail ? new_term : above_term;
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the Keith number tester: predictor, scoreboard, drivers.
`timescale 1ns / 1ps

// Predict each verdict and match results against it in arrival order
class keith_scoreboard;
  int          max_digits;
  bit          verdict_q[$];
  logic [31:0] cand_q[$];
  int          errors;
  int          checked;
  int          keith_seen;

  function new(int digits);
    max_digits = digits;
    errors     = 0;
    checked    = 0;
    keith_seen = 0;
  endfunction

  // Run the digit window until a term hits or passes the candidate
  function bit predict_keith(logic [31:0] cand);
    longint unsigned win [16];
    longint unsigned bound;
    longint unsigned rest;
    longint unsigned total;
    longint unsigned value;
    int              nd;
    int              i;
    int              step;
    value = cand;
    bound = 1;
    for (i = 0; i < max_digits; i++) bound = bound * 10;
    if (value < 10 || value >= bound) return 1'b0;
    nd   = 0;
    rest = value;
    while (rest != 0) begin
      nd++;
      rest = rest / 10;
    end
    // Seed the window most significant digit first
    rest = value;
    for (i = nd; i > 0; i--) begin
      win[i-1] = rest % 10;
      rest     = rest / 10;
    end
    for (step = 0; step < 256; step++) begin
      total = 0;
      for (i = 0; i < nd; i++) total = total + win[i];
      for (i = 0; i + 1 < nd; i++) win[i] = win[i+1];
      win[nd-1] = total;
      if (total == value) return 1'b1;
      if (total > value) return 1'b0;
    end
    return 1'b0;
  endfunction

  function void note_candidate(logic [31:0] cand);
    cand_q.push_back(cand);
    verdict_q.push_back(predict_keith(cand));
  endfunction

  function void check_verdict(logic flag);
    bit          want;
    logic [31:0] cand;
    if (verdict_q.size() == 0) begin
      $display("%0t: unexpected result beat, is_keith=%0b", $time, flag);
      errors++;
      return;
    end
    want = verdict_q.pop_front();
    cand = cand_q.pop_front();
    checked++;
    if (flag !== want) begin
      $display("%0t: candidate %0d is_keith expected %0b actual %0b", $time, cand, want, flag);
      errors++;
    end else if (want) begin
      keith_seen++;
    end
  endfunction

  function int pending();
    return verdict_q.size();
  endfunction
endclass

module tb_top;

  localparam int DIGIT_LIMIT   = 9;
  localparam int IDLE_LIMIT    = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 100;
  localparam int KEITH_COUNT   = 41;
  localparam int DIRECTED_SIZE = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] candidate = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_keith;

  keith_scoreboard verdicts;
  int unsigned     keith_set [KEITH_COUNT];
  int unsigned     directed_set [DIRECTED_SIZE];
  bit              hold_req = 1'b0;
  bit              calm = 1'b0;
  int              idle_cycles = 0;
  int              sent = 0;

  keith_number_test #(.MAX_DIGITS(DIGIT_LIMIT)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .candidate (candidate),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_keith  (is_keith)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Pick a gap length: none while calm, else mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Draw a candidate: known Keith numbers, near misses, each digit count, out of range
  function automatic logic [31:0] pick_candidate();
    int              r;
    int              nd;
    int              i;
    longint unsigned lo;
    longint unsigned span;
    r = $urandom_range(0, 99);
    if (r < 30) return keith_set[$urandom_range(0, KEITH_COUNT - 1)];
    if (r < 40) return keith_set[$urandom_range(0, KEITH_COUNT - 1)] + $urandom_range(0, 4) - 2;
    if (r < 70) begin
      nd = $urandom_range(2, DIGIT_LIMIT);
      lo = 1;
      for (i = 1; i < nd; i++) lo = lo * 10;
      span = lo * 9;
      return 32'(lo + ({32'b0, $urandom()} % span));
    end
    if (r < 80) return $urandom_range(0, 9);
    if (r < 90) return $urandom_range(32'hFFFF_FFFF, 1000000000);
    return $urandom();
  endfunction

  // Offer one beat after an optional gap and hold it until taken
  task automatic offer_beat(input logic [31:0] value, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    candidate <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic offer_random(input int count);
    int n;
    for (n = 0; n < count; n++) offer_beat(pick_candidate(), pick_gap());
  endtask

  // Drop valid and pause until every verdict has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts.pending() != 0) @(posedge clk);
  endtask

  // Track accepted beats on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) verdicts.note_candidate(candidate);
      if (out_valid && !out_stall) verdicts.check_verdict(is_keith);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL keith_number_test");
      $finish;
    end
  end

  // Drive output stall: random short and long holds, one long hold on request, no holds while calm
  initial begin
    int r;
    @(negedge rst);
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (calm || r < 60) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 2)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  initial begin
    int n;
    verdicts = new(DIGIT_LIMIT);
    keith_set = '{14, 19, 28, 47, 61, 75, 197, 742, 1104, 1537, 2208, 2580, 3684, 4788,
                  7385, 7647, 7909, 31331, 34285, 34348, 55604, 62662, 86935, 93993,
                  120284, 129106, 147640, 156146, 174680, 183186, 298320, 355419,
                  694280, 925993, 1084051, 7913837, 11436171, 33445755, 44121607,
                  129572008, 251133297};
    // Single digits, smallest two-digit and Keith values, digit-count edges, top of range
    directed_set = '{0, 1, 9, 10, 11, 13, 14, 15, 19, 28, 99, 100, 197, 742, 7909,
                     925993, 44121607, 129572008, 251133297, 251133298, 999999999,
                     1000000000, 32'h8000_0000, 32'hFFFF_FFFF};

    // Hold reset, then release it once
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < DIRECTED_SIZE; n++) offer_beat(directed_set[n], pick_gap());
    wait_drained();

    offer_random(500);

    // Back up the block behind a long output hold
    hold_req = 1'b1;
    for (n = 0; n < 24; n++) offer_beat(pick_candidate(), 0);
    wait_drained();

    // Run back to back with no idling on either side
    calm = 1'b1;
    offer_random(300);
    calm = 1'b0;
    wait_drained();

    offer_random(726);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d and checked %0d candidates (%0d Keith hits) across digit counts,",
             sent, verdicts.checked, verdicts.keith_seen);
    $display("out-of-range values, a long output hold, back-to-back bursts and random gaps.");
    if (verdicts.errors == 0 && verdicts.pending() == 0) begin
      $display("PASS keith_number_test");
    end else begin
      $display("FAIL keith_number_test");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/keith_pkg.sv
rtl/core/keith_cell.sv
rtl/core/keith_number_test.sv
verif/tb_top.sv
